// File: design/kgsr_pkg.sv
// shared types and constants for the k-group stream reverser
`default_nettype none
package kgsr_pkg;

  localparam int MAX_GROUP_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int CFG_W          = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      end_of_list;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic                      run_last;
    logic                      list_last;
  } out_item_t;

endpackage
`default_nettype wire

// File: design/k_group_stream_reverser_core.sv
// k-group stream reverser: top level with sequencer and output register
`default_nettype none
// Values stream in with an end-of-list flag and are held in a buffer memory
// until a run of group_size values is complete; the run then leaves newest
// first. If the list ends inside a run, the held values and the final value
// leave in arrival order. group_size 0 acts as 1, values above MAX_GROUP act
// as MAX_GROUP. An item that is only held is written to the buffer and the
// input stays open. An item that completes a run or ends the list is
// accepted, then its results are emitted one by one, with a buffer read
// before the first buffered value when the list ends inside a run. While the
// output is not stalled, the buffer gives one value per cycle through its
// single read port. While results are emitted in_ready is low; back pressure
// on the output stalls them.
// group_size is written through the cfg port, which is always ready, and
// must only be changed while the block is idle.
module k_group_stream_reverser_core import kgsr_pkg::*; #(
  parameter int MAX_GROUP  = MAX_GROUP_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_item,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_item
);

  localparam int AW = $clog2(MAX_GROUP);
  localparam int GW = $clog2(MAX_GROUP + 1);
  localparam int CW = (GW > CFG_W) ? GW : CFG_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_W-1:0]      cfg_r;
  logic [AW-1:0]         fill_r, fill_nxt;
  logic                  rev_r, rev_nxt;
  logic                  last_r, last_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  val_pend_r, val_pend_nxt;
  logic                  data_vld_r, data_vld_nxt;
  logic [AW-1:0]         reads_left_r, reads_left_nxt;
  logic [AW-1:0]         rd_addr_r, rd_addr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  logic [CW-1:0]         cfg_ext;
  logic [CW-1:0]         eff_g;
  logic                  complete;
  logic                  in_fire;
  logic [DATA_WIDTH-1:0] kept_val;
  logic                  wr_en;
  logic                  rd_en;
  logic [DATA_WIDTH-1:0] rd_data;
  logic                  out_free;
  logic                  can_val;
  logic                  can_data;
  logic                  take_val;
  logic                  take_data;
  logic                  is_final;
  logic                  running;

  kgsr_buf #(
    .DEPTH (MAX_GROUP),
    .WIDTH (DATA_WIDTH)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_r),
    .wr_data (kept_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CW'(cfg_r);

  always_comb begin
    if (cfg_r == '0) begin
      eff_g = CW'(1);
    end else if (cfg_ext > CW'(MAX_GROUP)) begin
      eff_g = CW'(MAX_GROUP);
    end else begin
      eff_g = cfg_ext;
    end
  end

  assign running  = (state_r == S_RUN);
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign complete = (CW'(fill_r) + CW'(1)) >= eff_g;
  assign kept_val = DATA_WIDTH'($unsigned(in_item.value));
  // buffer is written only while idle and read only while running
  assign wr_en    = in_fire & ~complete & ~in_item.end_of_list;

  assign out_free  = ~out_valid_r | out_ready;
  // reversed run: new value goes first; arrival order: new value goes last
  assign can_val   = val_pend_r & (rev_r | (~data_vld_r & (reads_left_r == '0)));
  assign can_data  = data_vld_r & ~(rev_r & val_pend_r);
  assign take_val  = running & out_free & can_val;
  assign take_data = running & out_free & can_data;
  assign rd_en     = running & (reads_left_r != '0) & (~data_vld_r | take_data);

  always_comb begin
    if (take_val) begin
      is_final = rev_r ? ((reads_left_r == '0) & ~data_vld_r) : 1'b1;
    end else begin
      is_final = rev_r & (reads_left_r == '0);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    rev_nxt        = rev_r;
    last_nxt       = last_r;
    val_nxt        = val_r;
    val_pend_nxt   = val_pend_r;
    data_vld_nxt   = data_vld_r;
    reads_left_nxt = reads_left_r;
    rd_addr_nxt    = rd_addr_r;
    out_valid_nxt  = out_valid_r & ~out_ready;
    out_item_nxt   = out_item_r;

    if (take_val | take_data) begin
      out_valid_nxt          = 1'b1;
      out_item_nxt.out_value = take_val ? VALUE_W'(val_r) : VALUE_W'(rd_data);
      out_item_nxt.run_last  = is_final;
      out_item_nxt.list_last = is_final & last_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (complete | in_item.end_of_list) begin
            state_nxt      = S_RUN;
            fill_nxt       = '0;
            rev_nxt        = complete;
            last_nxt       = in_item.end_of_list;
            val_nxt        = kept_val;
            val_pend_nxt   = 1'b1;
            data_vld_nxt   = 1'b0;
            reads_left_nxt = fill_r;
            rd_addr_nxt    = complete ? (fill_r - AW'(1)) : '0;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
      S_RUN: begin
        if (take_val) begin
          val_pend_nxt = 1'b0;
        end
        if (rd_en) begin
          data_vld_nxt   = 1'b1;
          reads_left_nxt = reads_left_r - AW'(1);
          rd_addr_nxt    = rev_r ? (rd_addr_r - AW'(1)) : (rd_addr_r + AW'(1));
        end else if (take_data) begin
          data_vld_nxt = 1'b0;
        end
        if (~val_pend_nxt & ~data_vld_nxt & (reads_left_nxt == '0)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_r        <= CFG_W'(1);
      fill_r       <= '0;
      rev_r        <= 1'b0;
      last_r       <= 1'b0;
      val_pend_r   <= 1'b0;
      data_vld_r   <= 1'b0;
      reads_left_r <= '0;
      rd_addr_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      rev_r        <= rev_nxt;
      last_r       <= last_nxt;
      val_pend_r   <= val_pend_nxt;
      data_vld_r   <= data_vld_nxt;
      reads_left_r <= reads_left_nxt;
      rd_addr_r    <= rd_addr_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid & cfg_ready) begin
        cfg_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

// File: design/kgsr_buf.sv
// group buffer memory: one write port, one read port with registered read data
`default_nettype none
module kgsr_buf import kgsr_pkg::*; #(
  parameter int DEPTH = MAX_GROUP_DEF,
  parameter int WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: design/kgsr_chk.sv
// port-level checker for the k-group stream reverser, bound to the top level
`default_nettype none
module kgsr_chk import kgsr_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_item
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  // the end of the list always closes a run
  a_list_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.list_last |-> out_item.run_last)
    else $error("list_last without run_last");

  // input stays closed while a run is still being emitted
  a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.run_last |-> !in_ready)
    else $error("input open in the middle of a run");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind k_group_stream_reverser_core kgsr_chk u_kgsr_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
`default_nettype wire
